@@ rtl/mnrs_pkg.sv @@
// mnrs_pkg: constants and types for the max non-negative run selector
// no dependencies
package mnrs_pkg;

   localparam int MAX_ITEMS   = 65536;
   localparam int SAMPLE_BITS = 32;

   localparam int POS_W   = 17;
   localparam int START_W = 16;
   localparam int LEN_W   = 17;
   localparam int SUM_W   = 47;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } run_type;

endpackage

@@ rtl/max_nonneg_run_select_unit.sv @@
// max_non_negative run selector, top level
// tracks the current and best run of non-negative samples, one item per cycle while req_ready is high
// depends on mnrs_pkg
//
// channel  direction  fields                                            handshake
// req      in         sample, last                                      req_valid / req_ready
// rsp      out        found, start_index, seg_length, seg_sum, too_long rsp_valid / rsp_ready
//
// one item per cycle while req_ready is high; the run add, the best compare
// and the result register form a single registered pass
// a result appears the cycle after its last item is accepted
// req_ready is low only while a result is held and rsp_ready is low
// reset (synchronous) clears run, best, position and the result valid
module max_nonneg_run_select_unit
   import mnrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_sample,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [START_W-1:0]        rsp_start_index,
   output logic [LEN_W-1:0]          rsp_seg_length,
   output logic [SUM_W-1:0]          rsp_seg_sum,
   output logic                      rsp_too_long
);

   logic [POS_W-1:0]   position_ff, position_in;
   run_type            run_ff, run_in;
   run_type            best_ff, best_in;
   logic               overflowed_ff, overflowed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [START_W-1:0] rsp_start_index_ff, rsp_start_index_in;
   logic [LEN_W-1:0]   rsp_seg_length_ff, rsp_seg_length_in;
   logic [SUM_W-1:0]   rsp_seg_sum_ff, rsp_seg_sum_in;
   logic               rsp_too_long_ff, rsp_too_long_in;

   logic                   accept;
   logic [SAMPLE_BITS-1:0] raw;
   logic                   negative;
   logic                   in_range;
   logic [SUM_W:0]         sum_add;
   run_type                run_ext;
   run_type                run_cur;
   run_type                best_new;
   logic                   close_now;
   logic                   better;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      raw      = req_sample[SAMPLE_BITS-1:0];
      negative = raw[SAMPLE_BITS-1];
      in_range = position_ff < POS_W'(MAX_ITEMS);

      sum_add = {1'b0, run_ff.sum} + (SUM_W+1)'(raw);
      run_ext.sum   = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[SUM_W-1:0];
      run_ext.len   = run_ff.len + LEN_W'(1);
      run_ext.start = (run_ff.len == '0) ? position_ff[START_W-1:0] : run_ff.start;

      run_cur   = (in_range && !negative) ? run_ext : run_ff;
      close_now = (in_range && negative) || req_last;

      better = (run_cur.len != '0) &&
               ((run_cur.sum > best_ff.sum) ||
                ((run_cur.sum == best_ff.sum) && (run_cur.len > best_ff.len)));
      best_new = (close_now && better) ? run_cur : best_ff;
   end

   always_comb begin
      position_in   = position_ff;
      run_in        = run_ff;
      best_in       = best_ff;
      overflowed_in = overflowed_ff;
      if (accept) begin
         if (req_last) begin
            position_in   = '0;
            run_in        = '0;
            best_in       = '0;
            overflowed_in = 1'b0;
         end else begin
            position_in   = in_range ? position_ff + POS_W'(1) : position_ff;
            run_in        = close_now ? '0 : run_cur;
            best_in       = best_new;
            overflowed_in = overflowed_ff || !in_range;
         end
      end
   end

   always_comb begin
      rsp_valid_in       = rsp_valid_ff;
      rsp_found_in       = rsp_found_ff;
      rsp_start_index_in = rsp_start_index_ff;
      rsp_seg_length_in  = rsp_seg_length_ff;
      rsp_seg_sum_in     = rsp_seg_sum_ff;
      rsp_too_long_in    = rsp_too_long_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_last) begin
         rsp_valid_in       = 1'b1;
         rsp_found_in       = best_new.len != '0;
         rsp_start_index_in = best_new.start;
         rsp_seg_length_in  = best_new.len;
         rsp_seg_sum_in     = best_new.sum;
         rsp_too_long_in    = overflowed_ff || !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         run_ff        <= '0;
         best_ff       <= '0;
         overflowed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         position_ff   <= position_in;
         run_ff        <= run_in;
         best_ff       <= best_in;
         overflowed_ff <= overflowed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_found_ff       <= rsp_found_in;
      rsp_start_index_ff <= rsp_start_index_in;
      rsp_seg_length_ff  <= rsp_seg_length_in;
      rsp_seg_sum_ff     <= rsp_seg_sum_in;
      rsp_too_long_ff    <= rsp_too_long_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_start_index = rsp_start_index_ff;
   assign rsp_seg_length  = rsp_seg_length_ff;
   assign rsp_seg_sum     = rsp_seg_sum_ff;
   assign rsp_too_long    = rsp_too_long_ff;

endmodule
